// ----- src/fbns_pkg.sv -----
// Shared types and constants for the nearest-neighbor frame scaler.
// Used by the divider, the generic RAM user and the top level.
`default_nettype none

package fbns_pkg;

    // Field widths of the stream beats and the configuration registers.
    localparam int COORD_W   = 11;
    localparam int DIM_W     = 10;
    localparam int PIX_W     = 16;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 3;

    // A scaled coordinate before division is one dimension times another.
    localparam int PROD_W = 2 * DIM_W;
    // Linear store address as computed, wide enough for row * src_width + column at any register values.
    localparam int CALC_W = 23;

    // Defaults for the top-level parameters.
    localparam int DEF_SRC_DEPTH  = 262144;
    localparam int DEF_PIXEL_BITS = 16;

    // Operation codes carried in the input tuser.
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_DOWN  = 2'd1;
    localparam logic [OP_W-1:0] OP_HIRES = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_ROWS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FREEZE     = 3'd5;

    // Register reset values.
    localparam logic [DIM_W-1:0] RST_SRC_WIDTH  = 10'd512;
    localparam logic [DIM_W-1:0] RST_SRC_HEIGHT = 10'd512;
    localparam logic [DIM_W-1:0] RST_DST_WIDTH  = 10'd292;
    localparam logic [DIM_W-1:0] RST_DST_HEIGHT = 10'd216;

    // Divider request and response.
    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [DIM_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PROD_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// ----- src/fbns_ram.sv -----
// Generic single-port synchronous RAM with a registered read port.
// No dependencies; width and depth come from parameters.
`default_nettype none

module fbns_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // On each clock: an optional write and an optional registered read, at the same address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/fbns_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on fbns_pkg for its request and response structs.
`default_nettype none

module fbns_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire fbns_pkg::t_div_req i_req,
    output fbns_pkg::t_div_rsp     o_rsp
);

    localparam int QW    = fbns_pkg::PROD_W;
    localparam int DW    = fbns_pkg::DIM_W;
    localparam int CNT_W = $clog2(QW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_rem;
    logic [QW-1:0]    r_quo;
    logic [DW-1:0]    r_dvs;

    logic [DW:0]      trial;
    logic             fits;
    logic [DW:0]      diff;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    always_comb begin
        trial = {r_rem, r_quo[QW-1]};
        fits  = (trial >= {1'b0, r_dvs});
        diff  = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
                r_quo <= {r_quo[QW-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

// ----- src/framebuffer_nearest_scaler.sv -----
// Nearest-neighbor frame scaler: source frame store, write path and two scaled read paths.
// Depends on fbns_pkg, fbns_div and fbns_ram.
// One item is in work at a time. A pixel write passes through S_PREP, S_ADDR,
// S_MEM and S_DONE before its result reaches the output register. A downsample
// read or a high-resolution sample adds S_DIVX, S_DIVY, S_CLAMP and S_RDAT. Each
// of the two coordinate quotients holds the sequencer while the bit-serial
// divider is started, works out its quotient bits and gives its done pulse. A
// rejected or empty read goes from S_PREP straight to S_DONE, and op code 3 is
// dropped with no result. A finished result waits in S_DONE for as long as it
// cannot enter the output register. The input accepts a new beat as soon as the
// previous result has moved into the output register, even if that result has
// not yet been taken. The frame store is one single-port RAM of SRC_DEPTH
// pixels at address row * src_width + column; it has no reset, and reading a
// pixel that was never written returns whatever the RAM holds.
`default_nettype none

module framebuffer_nearest_scaler #(
    parameter int SRC_DEPTH  = fbns_pkg::DEF_SRC_DEPTH,
    parameter int PIXEL_BITS = fbns_pkg::DEF_PIXEL_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // coord_x[10:0], coord_y[21:11], pixel_in[37:22], zeros
    input  wire logic [1:0]  i_s_tuser,   // op[1:0]
    // Output stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // pixel_out[15:0]
    output logic             o_m_tuser,   // range_error[0]
    // Configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [9:0]  i_cfg_data
);

    localparam int CW    = fbns_pkg::COORD_W;
    localparam int DW    = fbns_pkg::DIM_W;
    localparam int PW    = fbns_pkg::PIX_W;
    localparam int QW    = fbns_pkg::PROD_W;
    localparam int AC    = fbns_pkg::CALC_W;
    localparam int RAM_AW = (SRC_DEPTH > 1) ? $clog2(SRC_DEPTH) : 1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PREP  = 9'b000000010,
        S_DIVX  = 9'b000000100,
        S_DIVY  = 9'b000001000,
        S_CLAMP = 9'b000010000,
        S_ADDR  = 9'b000100000,
        S_MEM   = 9'b001000000,
        S_RDAT  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Configuration registers
    logic [DW-1:0] r_sw;
    logic [DW-1:0] r_sh;
    logic [DW-1:0] r_dw;
    logic [DW-1:0] r_dh;
    logic          r_flip;
    logic          r_freeze;
    logic          r_loaded;

    // Item registers
    logic [1:0]    r_op;
    logic [CW-1:0] r_x;
    logic [CW-1:0] r_y;
    logic [PW-1:0] r_pix_in;
    logic [QW-1:0] r_num_x;
    logic [QW-1:0] r_num_y;
    logic [QW-1:0] r_qx;
    logic [QW-1:0] r_qy;
    logic [DW-1:0] r_sx;
    logic [DW-1:0] r_sy;
    logic [AC-1:0] r_addr;
    logic          r_err;
    logic          r_rd_ok;
    logic [PW-1:0] r_res_pix;
    logic          r_res_err;

    // Output register
    logic          r_m_valid;
    logic [PW-1:0] r_m_pix;
    logic          r_m_err;

    logic          s_beat;
    logic          out_free;
    logic          x_neg;
    logic          y_neg;
    logic          wr_inside;
    logic          ds_inside;
    logic          hr_active;
    logic [DW-1:0] row_ds;
    logic [DW-1:0] gx;
    logic [DW-1:0] gy;
    logic          addr_ok;
    logic          ram_we;
    logic          ram_re;
    logic [PIXEL_BITS-1:0] ram_wdata;
    logic [PIXEL_BITS-1:0] ram_rdata;
    logic [PW-1:0] rd16;

    fbns_pkg::t_div_req div_req;
    fbns_pkg::t_div_rsp div_rsp;

    function automatic logic [PW-1:0] swap_bytes(input logic [PW-1:0] px);
        return {px[7:0], px[15:8]};
    endfunction

    assign s_beat      = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_m_valid || i_m_tready;

    // Configuration register file; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw     <= fbns_pkg::RST_SRC_WIDTH;
            r_sh     <= fbns_pkg::RST_SRC_HEIGHT;
            r_dw     <= fbns_pkg::RST_DST_WIDTH;
            r_dh     <= fbns_pkg::RST_DST_HEIGHT;
            r_flip   <= 1'b0;
            r_freeze <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                fbns_pkg::CFG_SRC_WIDTH:  r_sw     <= i_cfg_data;
                fbns_pkg::CFG_SRC_HEIGHT: r_sh     <= i_cfg_data;
                fbns_pkg::CFG_DST_WIDTH:  r_dw     <= i_cfg_data;
                fbns_pkg::CFG_DST_HEIGHT: r_dh     <= i_cfg_data;
                fbns_pkg::CFG_FLIP_ROWS:  r_flip   <= i_cfg_data[0];
                fbns_pkg::CFG_FREEZE:     r_freeze <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Range checks and the flipped target row, from the latched beat.
    always_comb begin
        x_neg     = r_x[CW-1];
        y_neg     = r_y[CW-1];
        wr_inside = !x_neg && !y_neg && (r_x[DW-1:0] < r_sw) && (r_y[DW-1:0] < r_sh);
        ds_inside = !x_neg && !y_neg && (r_x[DW-1:0] < r_dw) && (r_y[DW-1:0] < r_dh);
        hr_active = r_loaded && (r_sw != '0) && (r_sh != '0) &&
                    (r_dw != '0) && (r_dh != '0);
        row_ds    = r_flip ? (r_dh - DW'(1) - r_y[DW-1:0]) : r_y[DW-1:0];
    end

    // Clamp the high-resolution quotients into the source frame; negatives go to zero.
    always_comb begin
        if (x_neg) begin
            gx = '0;
        end else if (r_qx >= QW'(r_sw)) begin
            gx = r_sw - DW'(1);
        end else begin
            gx = r_qx[DW-1:0];
        end
        if (y_neg) begin
            gy = '0;
        end else if (r_qy >= QW'(r_sh)) begin
            gy = r_sh - DW'(1);
        end else begin
            gy = r_qy[DW-1:0];
        end
    end

    // Shared divider: x quotient first, then y.
    always_comb begin
        div_req.start    = ((r_state == S_DIVX) || (r_state == S_DIVY)) &&
                           !div_rsp.busy && !div_rsp.done;
        div_req.dividend = (r_state == S_DIVX) ? r_num_x : r_num_y;
        div_req.divisor  = (r_state == S_DIVX) ? r_dw : r_dh;
    end

    fbns_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Frame store access.
    assign addr_ok = (r_addr < AC'(SRC_DEPTH));
    assign ram_we  = (r_state == S_MEM) && (r_op == fbns_pkg::OP_WRITE) &&
                     !r_err && addr_ok && !r_freeze;
    assign ram_re  = (r_state == S_MEM) && (r_op != fbns_pkg::OP_WRITE) && addr_ok;

    generate
        if (PIXEL_BITS >= PW) begin : g_wide
            assign ram_wdata = PIXEL_BITS'(r_pix_in);
            assign rd16      = ram_rdata[PW-1:0];
        end else begin : g_narrow
            assign ram_wdata = r_pix_in[PIXEL_BITS-1:0];
            assign rd16      = PW'(ram_rdata);
        end
    endgenerate

    fbns_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (SRC_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (r_addr[RAM_AW-1:0]),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_beat) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                case (r_op)
                    fbns_pkg::OP_WRITE: n_state = S_ADDR;
                    fbns_pkg::OP_DOWN:  n_state = ds_inside ? S_DIVX : S_DONE;
                    fbns_pkg::OP_HIRES: n_state = hr_active ? S_DIVX : S_DONE;
                    default:            n_state = S_IDLE;
                endcase
            end
            S_DIVX: begin
                if (div_rsp.done) begin
                    n_state = S_DIVY;
                end
            end
            S_DIVY: begin
                if (div_rsp.done) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: n_state = S_ADDR;
            S_ADDR:  n_state = S_MEM;
            S_MEM:   n_state = (r_op == fbns_pkg::OP_WRITE) ? S_DONE : S_RDAT;
            S_RDAT:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Frame-loaded flag: set by the first write that reaches the store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= 1'b0;
        end else if (ram_we) begin
            r_loaded <= 1'b1;
        end
    end

    // Item datapath, stepped by the sequencer state.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op     <= i_s_tuser;
                r_x      <= i_s_tdata[CW-1:0];
                r_y      <= i_s_tdata[2*CW-1:CW];
                r_pix_in <= i_s_tdata[2*CW+PW-1:2*CW];
            end
            S_PREP: begin
                r_res_pix <= '0;
                r_sx      <= r_x[DW-1:0];
                r_sy      <= r_y[DW-1:0];
                r_err     <= !wr_inside;
                r_res_err <= (r_op == fbns_pkg::OP_DOWN) && !ds_inside;
                r_num_x   <= QW'(r_x[DW-1:0]) * QW'(r_sw);
                if (r_op == fbns_pkg::OP_DOWN) begin
                    r_num_y <= QW'(row_ds) * QW'(r_sh);
                end else begin
                    r_num_y <= QW'(r_y[DW-1:0]) * QW'(r_sh);
                end
            end
            S_DIVX: begin
                if (div_rsp.done) begin
                    r_qx <= div_rsp.quotient;
                end
            end
            S_DIVY: begin
                if (div_rsp.done) begin
                    r_qy <= div_rsp.quotient;
                end
            end
            S_CLAMP: begin
                if (r_op == fbns_pkg::OP_DOWN) begin
                    r_sx <= r_qx[DW-1:0];
                    r_sy <= r_qy[DW-1:0];
                end else begin
                    r_sx <= gx;
                    r_sy <= r_flip ? (r_sh - DW'(1) - gy) : gy;
                end
            end
            S_ADDR: begin
                r_addr <= AC'(r_sy) * AC'(r_sw) + AC'(r_sx);
            end
            S_MEM: begin
                r_rd_ok <= addr_ok;
                if (r_op == fbns_pkg::OP_WRITE) begin
                    r_res_pix <= '0;
                    r_res_err <= r_err || !addr_ok;
                end
            end
            S_RDAT: begin
                r_res_pix <= r_rd_ok ? swap_bytes(rd16) : '0;
                r_res_err <= 1'b0;
            end
            default: ;
        endcase
    end

    // Output register: the next item may start while a result waits here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_m_pix <= r_res_pix;
            r_m_err <= r_res_err;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_pix;
    assign o_m_tuser  = r_m_err;

    // A store write always leaves the frame marked as loaded.
    a_write_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_loaded)
        else $error("store write did not mark the frame loaded");

    // The divider is never started on a zero size.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> (div_req.divisor != '0))
        else $error("divider started with a zero divisor");

    // High-resolution samples never flag a range error.
    a_hires_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && r_res_err) |-> (r_op != fbns_pkg::OP_HIRES))
        else $error("range error raised on a high-resolution sample");

    // A finished result waits while the output register is still held.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && r_m_valid && !i_m_tready) |=> (r_state == S_DONE))
        else $error("result left the sequencer while the output was stalled");

endmodule

`default_nettype wire

// ----- tb/sv/framebuffer_nearest_scaler_tb.sv -----
// Self-checking testbench for the nearest-neighbor frame scaler.
// Needs fbns_pkg and framebuffer_nearest_scaler; drives both streams and the register
// port, keeps its own copy of the frame store and checks every result beat in order.
`default_nettype none

module framebuffer_nearest_scaler_tb;
    import fbns_pkg::*;

    localparam int STORE_DEPTH   = DEF_SRC_DEPTH;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;

    // Expected result of one input beat.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             range_err;
    } scaled_pixel_t;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata   = '0;
    logic [1:0]  i_s_tuser   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [15:0] o_m_tdata;
    logic        o_m_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [9:0]  i_cfg_data  = '0;

    // Register copies, as the block holds them after each accepted write.
    int src_w   = int'(RST_SRC_WIDTH);
    int src_h   = int'(RST_SRC_HEIGHT);
    int dst_w   = int'(RST_DST_WIDTH);
    int dst_h   = int'(RST_DST_HEIGHT);
    bit flip_q  = 1'b0;
    bit freeze_q = 1'b0;

    // Our own copy of the frame store; entries are marked once written.
    logic [PIX_W-1:0] frame_mem [STORE_DEPTH];
    bit               mem_written [STORE_DEPTH];
    bit               frame_loaded = 1'b0;

    scaled_pixel_t expected_pixels [$];
    int            mismatch_count = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            hold_req       = 0;
    int            hold_served    = 0;

    framebuffer_nearest_scaler u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2000000;
        $display("framebuffer_nearest_scaler regression: fail");
        $finish;
    end

    // Output-side ready: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_served) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_served++;
            end
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 100) begin
            $display("mismatch at %0t: %s got %h, expected %h", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    // Compare each accepted result beat with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        scaled_pixel_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected result beat, pixel", o_m_tdata, 0);
            end else begin
                want = expected_pixels.pop_front();
                if (o_m_tdata !== want.pixel) begin
                    report_mismatch("pixel_out", o_m_tdata, want.pixel);
                end
                if (o_m_tuser !== want.range_err) begin
                    report_mismatch("range_error", o_m_tuser, want.range_err);
                end
            end
        end
    end

    function automatic bit down_outside(input int x, input int y);
        return x < 0 || y < 0 || x >= dst_w || y >= dst_h;
    endfunction

    // Returns 1 when a read beat fetches a pixel from the store, with its address.
    function automatic bit source_addr(input logic [1:0] op, input int x, input int y,
                                       output int addr);
        int sx, sy, row;
        addr = 0;
        if (op == OP_DOWN) begin
            if (down_outside(x, y)) return 1'b0;
            row = flip_q ? dst_h - 1 - y : y;
            sx  = x * src_w / dst_w;
            sy  = row * src_h / dst_h;
        end else if (op == OP_HIRES) begin
            if (!frame_loaded || src_w == 0 || src_h == 0 || dst_w == 0 || dst_h == 0) begin
                return 1'b0;
            end
            // Scale first (truncating toward zero), then clamp, then flip.
            sx = x * src_w / dst_w;
            sy = y * src_h / dst_h;
            if (sx < 0) sx = 0;
            if (sy < 0) sy = 0;
            if (sx >= src_w) sx = src_w - 1;
            if (sy >= src_h) sy = src_h - 1;
            if (flip_q) sy = src_h - 1 - sy;
        end else begin
            return 1'b0;
        end
        addr = sy * src_w + sx;
        return addr < STORE_DEPTH;
    endfunction

    // Apply one accepted beat to the store copy and queue the result it causes.
    function automatic void frame_step(input logic [1:0] op, input int x, input int y,
                                       input logic [PIX_W-1:0] pix);
        scaled_pixel_t    res;
        logic [PIX_W-1:0] px;
        int               addr;
        res = '0;
        case (op)
            OP_WRITE: begin
                addr = y * src_w + x;
                if (x < 0 || y < 0 || x >= src_w || y >= src_h || addr >= STORE_DEPTH) begin
                    res.range_err = 1'b1;
                end else if (!freeze_q) begin
                    frame_mem[addr]   = pix;
                    mem_written[addr] = 1'b1;
                    frame_loaded      = 1'b1;
                end
            end
            OP_DOWN, OP_HIRES: begin
                if (op == OP_DOWN && down_outside(x, y)) begin
                    res.range_err = 1'b1;
                end else if (source_addr(op, x, y, addr)) begin
                    px        = frame_mem[addr];
                    res.pixel = {px[7:0], px[15:8]};
                end
            end
            default: return;
        endcase
        expected_pixels.push_back(res);
    endfunction

    // A read that would fetch a never-written pixel while writes are frozen.
    function automatic bit frozen_miss(input logic [1:0] op, input int x, input int y);
        int addr;
        if (!freeze_q || !source_addr(op, x, y, addr)) return 1'b0;
        return !mem_written[addr];
    endfunction

    // Offer one input beat, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_beat(input logic [1:0] op, input int x, input int y,
                             input logic [PIX_W-1:0] pix);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {2'b00, pix, 11'(y), 11'(x)};
        do @(posedge i_clk); while (!o_s_tready);
        frame_step(op, x, y, pix);
    endtask

    // Send an operation; a read of a pixel never written gets a write to it first.
    task automatic issue_op(input logic [1:0] op, input int x, input int y,
                            input logic [PIX_W-1:0] pix);
        int addr;
        if (source_addr(op, x, y, addr) && !mem_written[addr]) begin
            send_beat(OP_WRITE, addr % src_w, addr / src_w, 16'($urandom));
        end
        send_beat(op, x, y, pix);
    endtask

    // Mostly inside [0, span), sometimes on the edges or anywhere in the 11-bit field.
    function automatic int pick_coord(input int span);
        logic signed [10:0] raw;
        raw = 11'($urandom);
        case ($urandom_range(19))
            0, 1:    return int'(raw);
            2:       return -1;
            3:       return span;
            4:       return span - 1;
            default: return $urandom_range(span - 1);
        endcase
    endfunction

    task automatic send_random(input int count);
        int         done_n;
        logic [1:0] op;
        int         x, y;
        done_n = 0;
        while (done_n < count) begin
            op = ($urandom_range(99) < 5) ? OP_NONE : 2'($urandom_range(2));
            if (op == OP_WRITE) begin
                x = pick_coord(src_w);
                y = pick_coord(src_h);
            end else begin
                x = pick_coord(dst_w);
                y = pick_coord(dst_h);
            end
            if (!frozen_miss(op, x, y)) begin
                issue_op(op, x, y, 16'($urandom));
                if (op != OP_NONE) done_n++;
            end
        end
    endtask

    // Stop offering beats, wait for every expected result, then let the block settle.
    task automatic wait_drained;
        i_s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        logic [DIM_W-1:0] v;
        v = 10'(value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SRC_WIDTH:  src_w    = int'(v);
            CFG_SRC_HEIGHT: src_h    = int'(v);
            CFG_DST_WIDTH:  dst_w    = int'(v);
            CFG_DST_HEIGHT: dst_h    = int'(v);
            CFG_FLIP_ROWS:  flip_q   = v[0];
            CFG_FREEZE:     freeze_q = v[0];
            default: ;
        endcase
    endtask

    // Registers change only once the block has gone idle.
    task automatic set_config(input int sw, input int sh, input int dw, input int dh,
                              input bit flip, input bit frz);
        wait_drained;
        write_reg(CFG_SRC_WIDTH, sw);
        write_reg(CFG_SRC_HEIGHT, sh);
        write_reg(CFG_DST_WIDTH, dw);
        write_reg(CFG_DST_HEIGHT, dh);
        write_reg(CFG_FLIP_ROWS, flip);
        write_reg(CFG_FREEZE, frz);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Reset sizes: empty frame, ignored op, frame edges and clamping.
    task automatic test_reset_defaults;
        set_idle(0, 0);
        issue_op(OP_HIRES, 5, 5, 16'h0000);
        issue_op(OP_NONE, 1023, -1, 16'hFFFF);
        issue_op(OP_WRITE, 0, 0, 16'h1234);
        issue_op(OP_WRITE, 511, 511, 16'hABCD);
        issue_op(OP_WRITE, 512, 0, 16'h0000);
        issue_op(OP_WRITE, -1024, -1024, 16'hFFFF);
        issue_op(OP_WRITE, 0, 512, 16'h5A5A);
        issue_op(OP_DOWN, 0, 0, 16'h0000);
        issue_op(OP_DOWN, 291, 215, 16'h0000);
        issue_op(OP_DOWN, 292, 0, 16'h0000);
        issue_op(OP_DOWN, -1, 0, 16'h0000);
        issue_op(OP_DOWN, 0, 216, 16'h0000);
        issue_op(OP_HIRES, -1024, -1024, 16'h0000);
        issue_op(OP_HIRES, 1023, 1023, 16'h0000);
    endtask

    // Bottom-up rows: the downsample flips before scaling, the sample after clamping.
    task automatic test_row_flip;
        set_config(512, 512, 292, 216, 1'b1, 1'b0);
        issue_op(OP_DOWN, 0, 0, 16'h0000);
        issue_op(OP_HIRES, 0, 0, 16'h0000);
    endtask

    // Frozen writes store nothing but still flag coordinates outside the frame.
    task automatic test_frozen_writes;
        set_config(512, 512, 292, 216, 1'b0, 1'b1);
        issue_op(OP_WRITE, 0, 0, 16'hFFFF);
        issue_op(OP_WRITE, 1023, 0, 16'h0F0F);
        issue_op(OP_DOWN, 0, 0, 16'h0000);
    endtask

    // Zero sizes and sizes large enough to address past the end of the store.
    task automatic test_degenerate_sizes;
        set_config(512, 512, 0, 216, 1'b0, 1'b0);
        issue_op(OP_DOWN, 0, 0, 16'h0000);
        issue_op(OP_HIRES, 0, 0, 16'h0000);
        set_config(0, 512, 292, 216, 1'b0, 1'b0);
        issue_op(OP_WRITE, 0, 0, 16'h7777);
        issue_op(OP_HIRES, 0, 0, 16'h0000);
        issue_op(OP_DOWN, 0, 0, 16'h0000);
        set_config(1023, 1023, 2, 2, 1'b0, 1'b0);
        issue_op(OP_WRITE, 0, 300, 16'h4321);
        issue_op(OP_DOWN, 0, 1, 16'h0000);
        issue_op(OP_HIRES, 1023, 1023, 16'h0000);
    endtask

    // Random traffic under each idling mix, mostly on small frames.
    task automatic test_random_frames;
        int mode;
        for (mode = 0; mode < 4; mode++) begin
            case (mode)
                0:       set_idle(0, 0);
                1:       set_idle(70, 0);
                2:       set_idle(0, 70);
                default: set_idle(36, 36);
            endcase
            repeat (3) begin
                if ($urandom_range(2) != 0) begin
                    set_config($urandom_range(12, 1), $urandom_range(12, 1),
                               $urandom_range(12, 1), $urandom_range(12, 1),
                               $urandom_range(1), 1'b0);
                end else begin
                    set_config($urandom_range(512, 1), $urandom_range(512, 1),
                               $urandom_range(512, 1), $urandom_range(512, 1),
                               $urandom_range(1), 1'b0);
                end
                send_random(120);
            end
        end
    endtask

    // Sizes of 1 and 512 against each other, both ways round.
    task automatic test_size_extremes;
        set_idle(36, 36);
        set_config(1, 1, 512, 512, 1'b0, 1'b0);
        send_random(40);
        set_config(512, 512, 1, 1, 1'b1, 1'b0);
        send_random(40);
        set_config(512, 1, 1, 512, 1'b0, 1'b0);
        send_random(40);
        set_config(1, 512, 512, 1, 1'b1, 1'b0);
        send_random(40);
    endtask

    // Fill a small frame, then freeze it and keep reading and writing.
    task automatic test_frozen_random;
        set_idle(0, 0);
        set_config(6, 5, 9, 4, 1'b1, 1'b0);
        send_random(60);
        set_config(6, 5, 9, 4, 1'b1, 1'b1);
        send_random(50);
        set_config(6, 5, 9, 4, 1'b0, 1'b0);
    endtask

    // Long output stall with beats still offered, then a full pause of the input.
    task automatic test_backpressure;
        set_idle(0, 0);
        set_config(8, 8, 5, 11, 1'b0, 1'b0);
        hold_req++;
        send_random(12);
        wait_drained;
        send_random(12);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_row_flip();
        test_frozen_writes();
        test_degenerate_sizes();
        test_random_frames();
        test_size_extremes();
        test_frozen_random();
        test_backpressure();
        wait_drained();
        if (mismatch_count == 0) begin
            $display("framebuffer_nearest_scaler regression: pass");
        end else begin
            $display("framebuffer_nearest_scaler regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
